// ===== design/gpx_pkg.sv =====
// Package for the GPIO expander register map with LED strip output.
// Holds item, result and command types, register addresses and sizes.
// No dependencies; every design file imports it.
package gpx_pkg;

    localparam int REG_COUNT       = 255;
    localparam int STRIP_BYTES_MAX = 60;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] VERSION_WORD = 16'd1;

    localparam int ADR_LED        = 2;
    localparam int ADR_SAO_IN     = 3;
    localparam int ADR_SAO_OUT    = 4;
    localparam int ADR_SAO_MODE   = 5;
    localparam int ADR_GPIO_IN    = 6;
    localparam int ADR_GPIO_OUT   = 7;
    localparam int ADR_STRIP_LEN  = 9;
    localparam int ADR_STRIP_DATA = 10;
    localparam int STRIP_MODE_BIT = 2;

    localparam int LOW_FIRST = ADR_LED;
    localparam int LOW_LAST  = ADR_STRIP_DATA - 1;

    localparam int MEM_DEPTH   = REG_COUNT - ADR_STRIP_DATA;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int STRIP_LIMIT = (MEM_DEPTH < STRIP_BYTES_MAX) ? MEM_DEPTH : STRIP_BYTES_MAX;
    localparam int LEN_W       = $clog2(STRIP_LIMIT + 1);
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_POLL  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OP_CONST,
        OP_WR_LOW,
        OP_WR_MEM,
        OP_RD_LOW,
        OP_RD_MEM,
        OP_POLL
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_EMIT,
        ST_SREAD,
        ST_SEMIT
    } t_state;

    typedef struct packed {
        t_action    action;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [1:0] sao_pins;
        logic [6:0] gpio_pins;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status_led;
        logic [1:0] sao_levels;
        logic [1:0] sao_directions;
        logic [6:0] gpio_levels;
        logic       strip_enabled;
        logic       strip_valid;
        logic [7:0] strip_byte;
        logic       strip_last;
    } t_result;

    typedef struct packed {
        t_op        op;
        logic [7:0] addr;
        logic [7:0] data;
        logic [1:0] sao;
        logic [6:0] gpio;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
    } t_back_status;

endpackage

// ===== design/gpx_front.sv =====
// Front end: accepts input beats and classifies them into commands.
// Depends on gpx_pkg; feeds gpx_queue.
module gpx_front (
    input  logic           i_valid,
    input  gpx_pkg::t_item i_item,
    input  logic           i_enable,
    input  logic           i_q_full,
    output logic           o_ready,
    output logic           o_push,
    output gpx_pkg::t_cmd  o_cmd
);
    import gpx_pkg::*;

    logic is_low;
    logic is_mem;

    assign o_ready = i_enable && !i_q_full;
    assign o_push  = i_valid && o_ready;

    assign is_low = (i_item.reg_addr >= 8'(LOW_FIRST)) && (i_item.reg_addr <= 8'(LOW_LAST));
    assign is_mem = (i_item.reg_addr >= 8'(ADR_STRIP_DATA)) && (i_item.reg_addr < 8'(REG_COUNT));

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_CONST;
        o_cmd.addr = i_item.reg_addr;
        o_cmd.sao  = i_item.sao_pins;
        o_cmd.gpio = i_item.gpio_pins;
        case (i_item.action)
            ACT_WRITE: begin
                o_cmd.data = i_item.write_data;
                if (is_low) begin
                    o_cmd.op = OP_WR_LOW;
                end else if (is_mem) begin
                    o_cmd.op = OP_WR_MEM;
                end else begin
                    o_cmd.data = 8'd0;
                end
            end
            ACT_READ: begin
                if (i_item.reg_addr == 8'd0) begin
                    o_cmd.data = VERSION_WORD[7:0];
                end else if (i_item.reg_addr == 8'd1) begin
                    o_cmd.data = VERSION_WORD[15:8];
                end else if (is_low) begin
                    o_cmd.op = OP_RD_LOW;
                end else if (is_mem) begin
                    o_cmd.op = OP_RD_MEM;
                end
            end
            ACT_POLL: begin
                o_cmd.op = OP_POLL;
            end
            default: begin
                o_cmd.op = OP_CONST;
            end
        endcase
    end

endmodule

// ===== design/gpx_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on gpx_pkg for the command type and depth.
module gpx_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpx_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output gpx_pkg::t_cmd o_cmd
);
    import gpx_pkg::*;

    t_cmd                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/gpx_back.sv =====
// Back end: executes commands against the register file and streams strip bytes.
// Depends on gpx_pkg; holds the strip data memory and the output register.
module gpx_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  gpx_pkg::t_cmd         i_q_cmd,
    output logic                  o_q_pop,
    output gpx_pkg::t_back_status o_status,
    output logic                  o_valid,
    input  logic                  i_ready,
    output gpx_pkg::t_result      o_result
);
    import gpx_pkg::*;

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rdata;
    logic [7:0] r_low [LOW_FIRST:LOW_LAST];

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [MEM_AW-1:0] r_clr, n_clr;
    logic [LEN_W-1:0]  r_cursor, n_cursor;
    logic [LEN_W-1:0]  r_len, n_len;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_ra;
    logic              low_we;
    logic              poll_we;
    logic [7:0]        mem_off;
    logic [LEN_W-1:0]  clamp_len;
    logic              strip_on;
    logic              slot_free;
    t_result           pins;

    assign mem_off   = r_cmd.addr - 8'(ADR_STRIP_DATA);
    assign strip_on  = r_low[ADR_SAO_MODE][STRIP_MODE_BIT];
    assign clamp_len = (r_low[ADR_STRIP_LEN] > 8'(STRIP_LIMIT)) ? LEN_W'(STRIP_LIMIT)
                                                                : LEN_W'(r_low[ADR_STRIP_LEN]);
    assign slot_free = !r_out_valid || i_ready;

    assign o_valid             = r_out_valid;
    assign o_result            = r_out;
    assign o_status.clear_done = (r_state != ST_CLEAR);

    always_comb begin
        pins                = '0;
        pins.status_led     = r_low[ADR_LED][0];
        pins.sao_levels     = r_low[ADR_SAO_OUT][1:0];
        pins.sao_directions = r_low[ADR_SAO_MODE][1:0] | {1'b0, strip_on};
        pins.gpio_levels    = r_low[ADR_GPIO_OUT][6:0];
        pins.strip_enabled  = strip_on;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_clr       = r_clr;
        n_cursor    = r_cursor;
        n_len       = r_len;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = mem_off[MEM_AW-1:0];
        mem_wd      = r_cmd.data;
        mem_re      = 1'b0;
        mem_ra      = mem_off[MEM_AW-1:0];
        low_we      = 1'b0;
        poll_we     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = 8'd0;
                if (r_clr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_EMIT;
                case (r_cmd.op)
                    OP_WR_LOW: low_we = 1'b1;
                    OP_WR_MEM: mem_we = 1'b1;
                    OP_RD_MEM: mem_re = 1'b1;
                    OP_POLL: begin
                        poll_we = 1'b1;
                        if (strip_on && clamp_len != '0) begin
                            n_len    = clamp_len;
                            n_cursor = '0;
                            n_state  = ST_SREAD;
                        end
                    end
                    default: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out       = pins;
                    n_out_valid = 1'b1;
                    case (r_cmd.op)
                        OP_RD_MEM: n_out.read_data = r_rdata;
                        OP_RD_LOW: n_out.read_data = r_low[r_cmd.addr[3:0]];
                        OP_CONST:  n_out.read_data = r_cmd.data;
                        default:   n_out.read_data = 8'd0;
                    endcase
                    n_state = ST_IDLE;
                end
            end
            ST_SREAD: begin
                mem_re  = 1'b1;
                mem_ra  = MEM_AW'(r_cursor);
                n_state = ST_SEMIT;
            end
            ST_SEMIT: begin
                if (slot_free) begin
                    n_out             = pins;
                    n_out.strip_valid = 1'b1;
                    n_out.strip_byte  = r_rdata;
                    n_out.strip_last  = (r_cursor == r_len - 1'b1);
                    n_out_valid       = 1'b1;
                    if (r_cursor == r_len - 1'b1) begin
                        n_cursor = '0;
                        n_state  = ST_IDLE;
                    end else begin
                        n_cursor = r_cursor + 1'b1;
                        n_state  = ST_SREAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_len <= n_len;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
            for (int i = LOW_FIRST; i <= LOW_LAST; i++) begin
                r_low[i] <= 8'd0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
            if (low_we) begin
                r_low[r_cmd.addr[3:0]] <= r_cmd.data;
            end
            if (poll_we) begin
                r_low[ADR_SAO_IN]  <= {6'd0, r_cmd.sao};
                r_low[ADR_GPIO_IN] <= {1'b0, r_cmd.gpio};
            end
        end
    end

endmodule

// ===== design/gpio_expander_led_strip_regs.sv =====
// Top level of the GPIO expander register map with LED strip output.
// Depends on gpx_pkg, gpx_front, gpx_queue and gpx_back.
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_item   (gpx_pkg::t_item)
// result    out        o_valid / i_ready    o_result (gpx_pkg::t_result)
//
// With the back end idle, a register access or a quiet poll tick goes through the queue and
// the idle, execute and emit states to a registered result beat, and no new item is taken
// by the back end before it is idle again. A strip-mode poll tick gives one result beat per
// strip byte, alternating read and emit states, set by the single read port of the memory.
// After reset a clearing pass zeroes its 245 (REG_COUNT - 10) entries, taking no input beat.
// A stalled result holds the back end, while the front end keeps filling the two-entry queue.
module gpio_expander_led_strip_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gpx_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output gpx_pkg::t_result  o_result
);
    import gpx_pkg::*;

    t_cmd         front_cmd;
    t_cmd         q_cmd;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_valid;
    t_back_status back_status;

    gpx_front u_front (
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_enable (back_status.clear_done),
        .i_q_full (q_full),
        .o_ready  (o_ready),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    gpx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    gpx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (pop),
        .o_status  (back_status),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !back_status.clear_done |-> !o_ready)
        else $error("input beat offered during memory clearing pass");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("command queue overflow");

    a_last_is_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.strip_last) |-> o_result.strip_valid)
        else $error("strip_last on a beat without a strip byte");

    a_strip_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.strip_valid) |-> (o_result.read_data == 8'd0))
        else $error("strip beat carries read data");
`endif

endmodule
